FILE: design/rbms_pkg.sv
package rbms_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int COORD_W    = 8;
  localparam int ACT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 1'd1;

  localparam logic [ACT_W-1:0] ACT_TEST   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SET    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_INVERT = 4'd3;
  localparam logic [ACT_W-1:0] ACT_FILL   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_NEXT   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_PREV   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_FIRST  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_LAST   = 4'd8;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      fill_value;
  } in_t;

  typedef struct packed {
    logic                      pixel_bit;
    logic                      in_range;
    logic                      found;
    logic signed [COORD_W-1:0] found_x;
    logic signed [COORD_W-1:0] found_y;
  } out_t;

  typedef struct packed {
    logic latch;
    logic start;
    logic scan;
    logic write_row;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pixel_go;
    logic search_go;
    logic scan_end;
  } status_t;

endpackage

FILE: design/rbms_ctrl.sv
module rbms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rbms_pkg::status_t st,
  output rbms_pkg::cmd_t    cmd
);
  import rbms_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (st.pixel_go) state_next = S_WRITE;
        else if (st.search_go) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_end) state_next = S_DONE;
      end
      S_WRITE: begin
        cmd.write_row = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_START))
    else $error("accepted transaction did not start");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (state == S_DONE))
    else $error("row write did not finish");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

endmodule

FILE: design/rbms_datapath.sv
module rbms_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  rbms_pkg::in_t                   in_data,
  output rbms_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rbms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbms_pkg::CFG_W-1:0]      cfg_wdata,
  input  rbms_pkg::cmd_t                  cmd,
  output rbms_pkg::status_t               st
);
  import rbms_pkg::*;

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic                  base_bit;
  logic                  inv;

  logic [CFG_W-1:0] mask_width, mask_height;
  logic [CFG_W-1:0] w, h;

  in_t  req;
  out_t res, res_next;

  logic [ROW_W-1:0]     scan_row, start_row, rd_addr;
  logic                 scan_fwd, col_en;
  logic [MAX_WIDTH-1:0] col_mask, col_mask_next;
  logic [MAX_WIDTH-1:0] rd_data, row_val, width_mask, hit_bits, new_row;
  logic                 rd_vld;

  logic x_ok, y_ok, inr, is_pixel, is_search, fwd, search_fail, y_neg, y_ge_h;
  logic last_row, hit;
  logic [COL_W-1:0] hit_col, x_col;

  function automatic logic [COL_W-1:0] lowest_set(input logic [MAX_WIDTH-1:0] v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
      if (v[i]) idx = COL_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [COL_W-1:0] highest_set(input logic [MAX_WIDTH-1:0] v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (v[i]) idx = COL_W'(i);
    end
    return idx;
  endfunction

  assign w = (mask_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : mask_width;
  assign h = (mask_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : mask_height;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      width_mask[i] = CFG_W'(i) < w;
      if (fwd) col_mask_next[i] = $signed(COORD_W'(i)) > req.x_coord;
      else col_mask_next[i] = $signed(COORD_W'(i)) < req.x_coord;
    end
  end

  assign x_ok  = !req.x_coord[COORD_W-1] && (req.x_coord[CFG_W-1:0] < w);
  assign y_ok  = !req.y_coord[COORD_W-1] && (req.y_coord[CFG_W-1:0] < h);
  assign inr   = x_ok && y_ok;
  assign y_neg = req.y_coord[COORD_W-1];
  assign y_ge_h = !y_neg && (req.y_coord[CFG_W-1:0] >= h);
  assign x_col = req.x_coord[COL_W-1:0];

  always_comb begin
    is_pixel    = 1'b0;
    is_search   = 1'b0;
    fwd         = 1'b0;
    search_fail = 1'b0;
    start_row   = req.y_coord[ROW_W-1:0];
    case (req.action) inside
      ACT_TEST, ACT_SET, ACT_CLEAR: is_pixel = 1'b1;
      ACT_NEXT, ACT_FIRST: begin
        is_search = 1'b1;
        fwd       = 1'b1;
        if (req.action == ACT_FIRST || y_neg) begin
          start_row   = '0;
          search_fail = (h == '0);
        end else begin
          search_fail = y_ge_h;
        end
      end
      ACT_PREV, ACT_LAST: begin
        is_search = 1'b1;
        if (req.action == ACT_LAST || y_ge_h) begin
          start_row = ROW_W'(h - CFG_W'(1));
        end
        search_fail = (h == '0) || (req.action == ACT_PREV && y_neg);
      end
      default: ;
    endcase
  end

  assign st.pixel_go  = is_pixel && inr;
  assign st.search_go = is_search && !search_fail;

  assign row_val  = (rd_vld ? rd_data : {MAX_WIDTH{base_bit}}) ^ {MAX_WIDTH{inv}};
  assign hit_bits = row_val & width_mask &
                    ((col_en && scan_row == req.y_coord[ROW_W-1:0]) ? col_mask : '1);
  assign hit      = |hit_bits;
  assign hit_col  = scan_fwd ? lowest_set(hit_bits) : highest_set(hit_bits);
  assign last_row = scan_fwd ? ({1'b0, scan_row} == h - CFG_W'(1)) : (scan_row == '0);
  assign st.scan_end = hit || last_row;

  always_comb begin
    new_row = row_val;
    if (req.action == ACT_SET) new_row[x_col] = 1'b1;
    else if (req.action == ACT_CLEAR) new_row[x_col] = 1'b0;
  end

  always_comb begin
    res_next = res;
    if (cmd.start) begin
      res_next = '0;
      if (is_pixel || req.action == ACT_NEXT || req.action == ACT_PREV) res_next.in_range = inr;
      if (is_search && search_fail) begin
        res_next.found_x = fwd ? $signed(COORD_W'(w)) : '1;
        res_next.found_y = fwd ? $signed(COORD_W'(h)) : '1;
      end
    end
    if (cmd.scan && st.scan_end) begin
      res_next.found = hit;
      if (hit) begin
        res_next.found_x = $signed(COORD_W'(hit_col));
        res_next.found_y = $signed(COORD_W'(scan_row));
      end else begin
        res_next.found_x = scan_fwd ? $signed(COORD_W'(w)) : '1;
        res_next.found_y = scan_fwd ? $signed(COORD_W'(h)) : '1;
      end
    end
    if (cmd.write_row) res_next.pixel_bit = new_row[x_col];
  end

  always_comb begin
    if (cmd.start) rd_addr = start_row;
    else if (scan_fwd) rd_addr = scan_row + ROW_W'(1);
    else rd_addr = scan_row - ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_vld  <= row_valid[rd_addr];
    if (cmd.write_row) mem[scan_row] <= new_row ^ {MAX_WIDTH{inv}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      base_bit    <= 1'b0;
      inv         <= 1'b0;
      mask_width  <= CFG_W'(64);
      mask_height <= CFG_W'(64);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MASK_WIDTH:  mask_width  <= cfg_wdata;
          REG_MASK_HEIGHT: mask_height <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.start && req.action == ACT_INVERT) inv <= ~inv;
      if (cmd.start && req.action == ACT_FILL) begin
        row_valid <= '0;
        base_bit  <= req.fill_value;
        inv       <= 1'b0;
      end
      if (cmd.write_row) row_valid[scan_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req <= in_data;
    if (cmd.start || (cmd.scan && !st.scan_end)) scan_row <= rd_addr;
    if (cmd.start) begin
      scan_fwd <= fwd;
      col_en   <= (req.action == ACT_NEXT || req.action == ACT_PREV) &&
                  (req.y_coord[COORD_W-1:ROW_W] == '0);
      col_mask <= col_mask_next;
    end
    res <= res_next;
    if (cmd.load_out) out_data <= res;
  end

endmodule

FILE: design/raster_bitmap_mask_scan_core.sv
// Test, set and clear pass through the start, write and done states before the result loads;
// invert, fill, out-of-range pixel requests and searches that cover no row pass through start
// and done; a search scans N rows (N from 1 to 64) between them, one row per cycle with a
// priority encoder. One transaction at a time: the next is accepted in the cycle after the
// result loads, and a result waits in done while an earlier result is held by out_stall.
// Synchronous reset clears the mask through per-row valid bits and sets both sizes to 64.
module raster_bitmap_mask_scan_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rbms_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rbms_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rbms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbms_pkg::CFG_W-1:0]      cfg_wdata
);
  import rbms_pkg::*;

  cmd_t    cmd;
  status_t st;

  rbms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  rbms_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
